@@ src/imu_sample_ring_with_offset_top_assert.svh @@
// Assertion macros for the sample ring top level
`ifndef IMU_SAMPLE_RING_WITH_OFFSET_TOP_ASSERT_SVH
`define IMU_SAMPLE_RING_WITH_OFFSET_TOP_ASSERT_SVH

// Clocked check, off during reset
`define IMURING_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked implication check
`define IMURING_ASSERT_IMP(lbl, ante, cons, msg) \
  `IMURING_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

@@ src/imuring_pkg.sv @@
// Shared types, constants and helpers of the sample ring
`default_nettype none

package imuring_pkg;

  localparam int RING_DEPTH = 256;
  localparam int MAX_POP    = 64;
  localparam int NUM_AXES   = 6;
  localparam int AXIS_W     = 16;
  localparam int FILL_W     = 8;
  localparam int REQ_W      = 7;
  localparam int CFG_IDX_W  = 8;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int CMP_W      = (PTR_W > REQ_W) ? PTR_W : REQ_W;

  localparam int AX_ACCEL_X = 0;
  localparam int AX_ACCEL_Y = 1;
  localparam int AX_ACCEL_Z = 2;
  localparam int AX_GYRO_X  = 3;
  localparam int AX_GYRO_Y  = 4;
  localparam int AX_GYRO_Z  = 5;

  typedef logic signed [AXIS_W-1:0] axis_t;
  typedef axis_t [NUM_AXES-1:0] sample_t;
  localparam int SAMPLE_W = $bits(sample_t);

  localparam axis_t AXIS_MIN = 16'sh8000;
  localparam axis_t AXIS_MAX = 16'sh7fff;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef enum logic [0:0] {
    FUNC_PUSH = 1'b0,
    FUNC_POP  = 1'b1
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OFS_ACCEL_X = 8'd0,
    REG_OFS_ACCEL_Y = 8'd1,
    REG_OFS_ACCEL_Z = 8'd2,
    REG_OFS_GYRO_X  = 8'd3,
    REG_OFS_GYRO_Y  = 8'd4,
    REG_OFS_GYRO_Z  = 8'd5
  } cfg_reg_e;

  typedef struct packed {
    logic              data_valid;
    logic              last;
    logic              dropped;
    logic              batch;
    logic [FILL_W-1:0] fill;
  } meta_t;

  typedef struct packed {
    logic  vld;
    meta_t meta;
  } issue_t;

  typedef struct packed {
    logic    we;
    ptr_t    waddr;
    sample_t wdata;
    logic    re;
    ptr_t    raddr;
  } ram_req_t;

  typedef struct packed {
    logic busy;
    ptr_t fill;
  } ctrl_st_t;

  function automatic ptr_t ring_next(ptr_t p);
    return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + ptr_t'(1);
  endfunction

  function automatic logic [FILL_W-1:0] to_fill(ptr_t f);
    logic [PTR_W+FILL_W-1:0] w;
    w = {{FILL_W{1'b0}}, f};
    return w[FILL_W-1:0];
  endfunction

  function automatic axis_t sat_add(axis_t a, axis_t b);
    logic signed [AXIS_W:0] s;
    s = {a[AXIS_W-1], a} + {b[AXIS_W-1], b};
    if (s[AXIS_W] != s[AXIS_W-1]) begin
      return s[AXIS_W] ? AXIS_MIN : AXIS_MAX;
    end
    return s[AXIS_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ src/imuring_if.sv @@
// Handshake channels of the sample ring: input, result and register write
`default_nettype none

interface imuring_in_if import imuring_pkg::*;;
  logic             valid;
  logic             ready;
  logic [0:0]       func;
  axis_t            accel_x;
  axis_t            accel_y;
  axis_t            accel_z;
  axis_t            gyro_x;
  axis_t            gyro_y;
  axis_t            gyro_z;
  logic             end_of_batch;
  logic [REQ_W-1:0] request_count;

  modport source (output valid, func, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                  end_of_batch, request_count, input ready);
  modport sink   (input valid, func, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                  end_of_batch, request_count, output ready);
endinterface

interface imuring_out_if import imuring_pkg::*;;
  logic              valid;
  logic              ready;
  logic              data_valid;
  axis_t             out_accel_x;
  axis_t             out_accel_y;
  axis_t             out_accel_z;
  axis_t             out_gyro_x;
  axis_t             out_gyro_y;
  axis_t             out_gyro_z;
  logic              last_of_run;
  logic              dropped_oldest;
  logic              batch_ready;
  logic [FILL_W-1:0] fill_level;

  modport source (output valid, data_valid, out_accel_x, out_accel_y, out_accel_z,
                  out_gyro_x, out_gyro_y, out_gyro_z, last_of_run, dropped_oldest,
                  batch_ready, fill_level, input ready);
  modport sink   (input valid, data_valid, out_accel_x, out_accel_y, out_accel_z,
                  out_gyro_x, out_gyro_y, out_gyro_z, last_of_run, dropped_oldest,
                  batch_ready, fill_level, output ready);
endinterface

interface imuring_cfg_if import imuring_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  axis_t                data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ src/imuring_ram.sv @@
// Generic single-write, single-read RAM with registered read data
`default_nettype none

module imuring_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ src/imuring_ctrl.sv @@
// Pointer keeper and pop sequencer of the sample ring
`default_nettype none

module imuring_ctrl import imuring_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  imuring_in_if.sink in_i,
  input  wire logic  s1_free_i,
  output issue_t     iss_o,
  output ram_req_t   ram_o,
  output ctrl_st_t   st_o
);

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_POP
  } state_e;

  state_e           state_q, state_d;
  ptr_t             wp_q, wp_d;
  ptr_t             rp_q, rp_d;
  logic [REQ_W-1:0] cnt_q, cnt_d;

  ptr_t             fill;
  logic             full;
  logic             accept;
  logic [REQ_W-1:0] req_sat;
  logic [CMP_W-1:0] fill_c;
  logic [CMP_W-1:0] req_c;
  logic [REQ_W-1:0] n_pop;

  assign fill    = (wp_q - rp_q) + ((wp_q < rp_q) ? PTR_W'(RING_DEPTH) : '0);
  assign full    = (fill == PTR_W'(RING_DEPTH - 1));
  assign req_sat = (in_i.request_count > REQ_W'(MAX_POP)) ? REQ_W'(MAX_POP)
                                                         : in_i.request_count;
  assign fill_c  = CMP_W'(fill);
  assign req_c   = CMP_W'(req_sat);
  assign n_pop   = (fill_c < req_c) ? REQ_W'(fill_c) : req_sat;

  assign in_i.ready = (state_q == ST_IDLE) && s1_free_i;
  assign accept     = in_i.valid && in_i.ready;

  assign st_o.busy = (state_q == ST_POP);
  assign st_o.fill = fill;

  always_comb begin
    state_d = state_q;
    wp_d    = wp_q;
    rp_d    = rp_q;
    cnt_d   = cnt_q;
    ram_o   = '0;
    iss_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (func_e'(in_i.func) == FUNC_PUSH)) begin
          ram_o.we                    = 1'b1;
          ram_o.waddr                 = wp_q;
          ram_o.wdata[AX_ACCEL_X]     = in_i.accel_x;
          ram_o.wdata[AX_ACCEL_Y]     = in_i.accel_y;
          ram_o.wdata[AX_ACCEL_Z]     = in_i.accel_z;
          ram_o.wdata[AX_GYRO_X]      = in_i.gyro_x;
          ram_o.wdata[AX_GYRO_Y]      = in_i.gyro_y;
          ram_o.wdata[AX_GYRO_Z]      = in_i.gyro_z;
          wp_d                        = ring_next(wp_q);
          iss_o.vld                   = 1'b1;
          iss_o.meta.last             = 1'b1;
          iss_o.meta.dropped          = full;
          iss_o.meta.batch            = in_i.end_of_batch;
          if (full) begin
            rp_d            = ring_next(rp_q);
            iss_o.meta.fill = to_fill(fill);
          end else begin
            iss_o.meta.fill = to_fill(fill + ptr_t'(1));
          end
        end else if (accept) begin
          iss_o.vld       = 1'b1;
          iss_o.meta.last = 1'b1;
          iss_o.meta.fill = to_fill(fill);
          if (n_pop != '0) begin
            ram_o.re              = 1'b1;
            ram_o.raddr           = rp_q;
            rp_d                  = ring_next(rp_q);
            iss_o.meta.data_valid = 1'b1;
            iss_o.meta.last       = (n_pop == REQ_W'(1));
            iss_o.meta.fill       = to_fill(fill - ptr_t'(1));
            cnt_d                 = n_pop - REQ_W'(1);
            if (n_pop != REQ_W'(1)) begin
              state_d = ST_POP;
            end
          end
        end
      end
      ST_POP: begin
        if (s1_free_i) begin
          ram_o.re              = 1'b1;
          ram_o.raddr           = rp_q;
          rp_d                  = ring_next(rp_q);
          iss_o.vld             = 1'b1;
          iss_o.meta.data_valid = 1'b1;
          iss_o.meta.last       = (cnt_q == REQ_W'(1));
          iss_o.meta.fill       = to_fill(fill - ptr_t'(1));
          cnt_d                 = cnt_q - REQ_W'(1);
          if (cnt_q == REQ_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      wp_q    <= '0;
      rp_q    <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

@@ src/imuring_outstg.sv @@
// Offset registers, saturating offset add and the two-stage result pipeline
`default_nettype none

module imuring_outstg import imuring_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  imuring_cfg_if.sink    cfg_i,
  input  wire issue_t    iss_i,
  input  wire sample_t   rdata_i,
  output logic           s1_free_o,
  imuring_out_if.source  out_o
);

  axis_t   ofs_q [NUM_AXES];
  axis_t   ofs_d [NUM_AXES];
  logic    s1_vld_q, s1_vld_d;
  meta_t   s1_meta_q, s1_meta_d;
  logic    s2_vld_q, s2_vld_d;
  meta_t   s2_meta_q, s2_meta_d;
  sample_t s2_smp_q, s2_smp_d;
  logic    s2_load;

  assign cfg_i.ready = 1'b1;
  assign s2_load     = s1_vld_q && (!s2_vld_q || out_o.ready);
  assign s1_free_o   = !s1_vld_q || s2_load;

  always_comb begin
    ofs_d = ofs_q;
    if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_OFS_ACCEL_X: ofs_d[AX_ACCEL_X] = cfg_i.data;
        REG_OFS_ACCEL_Y: ofs_d[AX_ACCEL_Y] = cfg_i.data;
        REG_OFS_ACCEL_Z: ofs_d[AX_ACCEL_Z] = cfg_i.data;
        REG_OFS_GYRO_X:  ofs_d[AX_GYRO_X]  = cfg_i.data;
        REG_OFS_GYRO_Y:  ofs_d[AX_GYRO_Y]  = cfg_i.data;
        REG_OFS_GYRO_Z:  ofs_d[AX_GYRO_Z]  = cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    s1_vld_d  = s1_vld_q;
    s1_meta_d = s1_meta_q;
    if (s1_free_o) begin
      s1_vld_d  = iss_i.vld;
      s1_meta_d = iss_i.meta;
    end
  end

  always_comb begin
    s2_vld_d  = s2_vld_q;
    s2_meta_d = s2_meta_q;
    s2_smp_d  = s2_smp_q;
    if (s2_load) begin
      s2_vld_d  = 1'b1;
      s2_meta_d = s1_meta_q;
      for (int k = 0; k < NUM_AXES; k++) begin
        s2_smp_d[k] = s1_meta_q.data_valid ? sat_add(rdata_i[k], ofs_q[k]) : '0;
      end
    end else if (out_o.ready) begin
      s2_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        ofs_q[k] <= '0;
      end
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      ofs_q    <= ofs_d;
      s1_vld_q <= s1_vld_d;
      s2_vld_q <= s2_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_meta_q <= s1_meta_d;
    s2_meta_q <= s2_meta_d;
    s2_smp_q  <= s2_smp_d;
  end

  assign out_o.valid          = s2_vld_q;
  assign out_o.data_valid     = s2_meta_q.data_valid;
  assign out_o.out_accel_x    = s2_smp_q[AX_ACCEL_X];
  assign out_o.out_accel_y    = s2_smp_q[AX_ACCEL_Y];
  assign out_o.out_accel_z    = s2_smp_q[AX_ACCEL_Z];
  assign out_o.out_gyro_x     = s2_smp_q[AX_GYRO_X];
  assign out_o.out_gyro_y     = s2_smp_q[AX_GYRO_Y];
  assign out_o.out_gyro_z     = s2_smp_q[AX_GYRO_Z];
  assign out_o.last_of_run    = s2_meta_q.last;
  assign out_o.dropped_oldest = s2_meta_q.dropped;
  assign out_o.batch_ready    = s2_meta_q.batch;
  assign out_o.fill_level     = s2_meta_q.fill;

endmodule

`default_nettype wire

@@ src/imu_sample_ring_with_offset_top.sv @@
// Top level of the motion sample ring with per-axis saturating read offsets
// Push: its single beat passes through the stage 1 and stage 2 registers to the result port.
// Pop of n samples: the sequencer issues one sample store read per cycle while stage 1 is free;
// the first beat passes through the stage 1 and stage 2 registers, then one beat per cycle while out ready is high.
// The single read port of the sample store sets the pop rate; a new item waits for the run.
// Reset clears pointers, offsets and pipeline valids; no clearing pass over the store.
`default_nettype none

`include "imu_sample_ring_with_offset_top_assert.svh"

module imu_sample_ring_with_offset_top import imuring_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  imuring_cfg_if.sink   cfg_i,
  imuring_in_if.sink    in_i,
  imuring_out_if.source out_o
);

  issue_t   iss;
  ram_req_t ram_req;
  ctrl_st_t st;
  sample_t  rdata;
  logic     s1_free;
  logic     push_acc;
  logic     ring_full;
  logic     beat_empty;
  logic     smp_zero;

  imuring_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .s1_free_i (s1_free),
    .iss_o     (iss),
    .ram_o     (ram_req),
    .st_o      (st)
  );

  imuring_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (RING_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (rdata)
  );

  imuring_outstg u_outstg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_i),
    .iss_i     (iss),
    .rdata_i   (rdata),
    .s1_free_o (s1_free),
    .out_o     (out_o)
  );

  assign push_acc   = in_i.valid && in_i.ready && (func_e'(in_i.func) == FUNC_PUSH);
  assign ring_full  = (st.fill == PTR_W'(RING_DEPTH - 1));
  assign beat_empty = out_o.valid && !out_o.data_valid;
  assign smp_zero   = (out_o.out_accel_x == '0) && (out_o.out_gyro_z == '0);

  `IMURING_ASSERT_IMP(a_run_has_data, st.busy, st.fill != '0, "pop run on empty ring")
  `IMURING_ASSERT_IMP(a_full_push, push_acc && ring_full, ##1 ring_full, "full push moved fill")
  `IMURING_ASSERT_IMP(a_empty_beat, beat_empty, out_o.last_of_run && smp_zero, "bad empty beat")

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// Testbench of the motion sample ring: random and directed pushes and pops, offset writes
`timescale 1ns / 100ps

module testbench;
  import imuring_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int MAX_REPORTS    = 40;

  typedef enum {OFS_RANDOM, OFS_TOP, OFS_BOTTOM, OFS_ZERO} ofs_style_e;

  typedef struct packed {
    func_e            op;
    sample_t          smp;
    logic             eob;
    logic [REQ_W-1:0] cnt;
  } ring_op_t;

  typedef struct packed {
    logic              data_valid;
    sample_t           smp;
    logic              last;
    logic              dropped;
    logic              batch;
    logic [FILL_W-1:0] fill;
  } ring_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  imuring_cfg_if cfg_if ();
  imuring_in_if  in_if ();
  imuring_out_if out_if ();

  imu_sample_ring_with_offset_top u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // stimulus side
  ring_op_t             in_pend[$];
  ring_op_t             in_cur = '0;
  logic                 in_vld = 1'b0;
  logic                 in_taken = 1'b0;
  int                   in_gap = 0;
  logic                 out_rdy = 1'b0;
  logic                 out_taken = 1'b0;
  int                   out_stall = 0;
  logic                 cfg_vld = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  axis_t                cfg_dat = '0;
  bit                   busy_in = 1'b0;
  bit                   busy_out = 1'b0;

  // predicted ring state
  axis_t      ofs_reg [NUM_AXES];
  sample_t    ring_mem [RING_DEPTH];
  int         wr_idx = 0;
  int         rd_idx = 0;
  ring_beat_t beats_due[$];

  int err_count = 0;
  int beats_checked = 0;
  int pushes_seen = 0;
  int drops_seen = 0;
  int pops_seen = 0;
  int empty_pops = 0;
  int reg_writes = 0;
  int idle_cycles = 0;

  string axis_tag [NUM_AXES] = '{"accel_x", "accel_y", "accel_z", "gyro_x", "gyro_y", "gyro_z"};

  assign cfg_if.valid = cfg_vld;
  assign cfg_if.index = cfg_idx;
  assign cfg_if.data  = cfg_dat;

  assign in_if.valid         = in_vld;
  assign in_if.func          = in_cur.op;
  assign in_if.accel_x       = in_cur.smp[AX_ACCEL_X];
  assign in_if.accel_y       = in_cur.smp[AX_ACCEL_Y];
  assign in_if.accel_z       = in_cur.smp[AX_ACCEL_Z];
  assign in_if.gyro_x        = in_cur.smp[AX_GYRO_X];
  assign in_if.gyro_y        = in_cur.smp[AX_GYRO_Y];
  assign in_if.gyro_z        = in_cur.smp[AX_GYRO_Z];
  assign in_if.end_of_batch  = in_cur.eob;
  assign in_if.request_count = in_cur.cnt;

  assign out_if.ready = out_rdy;

  initial begin
    foreach (ofs_reg[a]) ofs_reg[a] = '0;
    forever #10 clk = ~clk;
  end

  function automatic int ring_count();
    return (wr_idx - rd_idx + RING_DEPTH) % RING_DEPTH;
  endfunction

  function automatic axis_t clamp_sum(axis_t a, axis_t b);
    int s;
    s = int'(a) + int'(b);
    if (s > int'(AXIS_MAX)) s = int'(AXIS_MAX);
    if (s < int'(AXIS_MIN)) s = int'(AXIS_MIN);
    return axis_t'(s);
  endfunction

  function automatic void ring_apply(ring_op_t op);
    ring_beat_t b;
    int want;
    int n;
    b = '0;
    if (op.op == FUNC_PUSH) begin
      pushes_seen++;
      if (ring_count() >= RING_DEPTH - 1) begin
        rd_idx = (rd_idx + 1) % RING_DEPTH;
        b.dropped = 1'b1;
        drops_seen++;
      end
      ring_mem[wr_idx] = op.smp;
      wr_idx = (wr_idx + 1) % RING_DEPTH;
      b.last = 1'b1;
      b.batch = op.eob;
      b.fill = FILL_W'(ring_count());
      beats_due.push_back(b);
    end else begin
      pops_seen++;
      want = (int'(op.cnt) > MAX_POP) ? MAX_POP : int'(op.cnt);
      n = (want < ring_count()) ? want : ring_count();
      if (n == 0) begin
        empty_pops++;
        b.last = 1'b1;
        b.fill = FILL_W'(ring_count());
        beats_due.push_back(b);
      end
      for (int k = 0; k < n; k++) begin
        b = '0;
        b.data_valid = 1'b1;
        for (int a = 0; a < NUM_AXES; a++) b.smp[a] = clamp_sum(ring_mem[rd_idx][a], ofs_reg[a]);
        rd_idx = (rd_idx + 1) % RING_DEPTH;
        b.last = (k == n - 1);
        b.fill = FILL_W'(ring_count());
        beats_due.push_back(b);
      end
    end
  endfunction

  function automatic void field_cmp(string fname, logic [AXIS_W-1:0] want,
                                    logic [AXIS_W-1:0] got);
    if (got !== want) begin
      err_count++;
      if (err_count <= MAX_REPORTS)
        $display("%0t: %s expected %h, got %h", $time, fname, want, got);
    end
  endfunction

  function automatic int pause_draw(bit busy);
    return busy ? $urandom_range(0, 12) : 0;
  endfunction

  // monitor: sample all channels at the rising edge
  always @(posedge clk) begin
    ring_beat_t want;
    sample_t got_smp;
    if (rst_n) begin
      in_taken <= in_if.valid && in_if.ready;
      out_taken <= out_if.valid && out_if.ready;
      if (cfg_if.valid && cfg_if.ready) begin
        reg_writes++;
        if (cfg_if.index < NUM_AXES) ofs_reg[cfg_if.index] = cfg_if.data;
      end
      if (in_if.valid && in_if.ready) ring_apply(in_cur);
      if (out_if.valid && out_if.ready) begin
        got_smp[AX_ACCEL_X] = out_if.out_accel_x;
        got_smp[AX_ACCEL_Y] = out_if.out_accel_y;
        got_smp[AX_ACCEL_Z] = out_if.out_accel_z;
        got_smp[AX_GYRO_X]  = out_if.out_gyro_x;
        got_smp[AX_GYRO_Y]  = out_if.out_gyro_y;
        got_smp[AX_GYRO_Z]  = out_if.out_gyro_z;
        if (beats_due.size() == 0) begin
          err_count++;
          $display("%0t: result beat with nothing expected, expected none, got fill %0d",
                   $time, out_if.fill_level);
        end else begin
          want = beats_due.pop_front();
          beats_checked++;
          field_cmp("data_valid", want.data_valid, out_if.data_valid);
          for (int a = 0; a < NUM_AXES; a++) field_cmp(axis_tag[a], want.smp[a], got_smp[a]);
          field_cmp("last_of_run", want.last, out_if.last_of_run);
          field_cmp("dropped_oldest", want.dropped, out_if.dropped_oldest);
          field_cmp("batch_ready", want.batch, out_if.batch_ready);
          field_cmp("fill_level", want.fill, out_if.fill_level);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
                 $time, idle_cycles, beats_due.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // driver: hold the item until taken, then wait its gap and advance
  always @(negedge clk) begin
    if (rst_n && (!in_vld || in_taken)) begin
      if (in_gap > 0) begin
        in_vld <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (in_pend.size() != 0) begin
        in_cur <= in_pend.pop_front();
        in_vld <= 1'b1;
        in_gap <= pause_draw(busy_in);
      end else begin
        in_vld <= 1'b0;
      end
    end
  end

  // result side: after each beat, a random stall while busy_out is set
  always @(negedge clk) begin
    int hold;
    if (out_taken) begin
      hold = pause_draw(busy_out);
      out_rdy <= (hold == 0);
      out_stall <= (hold == 0) ? 0 : hold - 1;
    end else if (out_stall > 0) begin
      out_rdy <= 1'b0;
      out_stall <= out_stall - 1;
    end else begin
      out_rdy <= 1'b1;
    end
  end

  function automatic axis_t rand_axis();
    case ($urandom_range(0, 7))
      0: return AXIS_MIN;
      1: return AXIS_MAX;
      2: return axis_t'($urandom_range(0, 32)) - axis_t'(16);
      default: return axis_t'($urandom);
    endcase
  endfunction

  function automatic sample_t rand_sample();
    sample_t s;
    for (int a = 0; a < NUM_AXES; a++) s[a] = rand_axis();
    return s;
  endfunction

  function automatic sample_t smp_split(axis_t acc, axis_t gyr);
    sample_t s;
    s[AX_ACCEL_X] = acc;
    s[AX_ACCEL_Y] = acc;
    s[AX_ACCEL_Z] = acc;
    s[AX_GYRO_X]  = gyr;
    s[AX_GYRO_Y]  = gyr;
    s[AX_GYRO_Z]  = gyr;
    return s;
  endfunction

  function automatic void push_q(sample_t s, logic eob);
    ring_op_t op;
    op.op = FUNC_PUSH;
    op.smp = s;
    op.eob = eob;
    op.cnt = REQ_W'($urandom);
    in_pend.push_back(op);
  endfunction

  function automatic void pop_q(logic [REQ_W-1:0] cnt);
    ring_op_t op;
    op.op = FUNC_POP;
    op.smp = rand_sample();
    op.eob = 1'($urandom);
    op.cnt = cnt;
    in_pend.push_back(op);
  endfunction

  function automatic void mix_queue(int n);
    repeat (n) begin
      if ($urandom_range(0, 99) < 55) begin
        push_q(rand_sample(), 1'($urandom));
      end else begin
        case ($urandom_range(0, 9))
          0: pop_q('0);
          1: pop_q(REQ_W'($urandom_range(2 ** REQ_W - 1, MAX_POP + 1)));
          2: pop_q(REQ_W'(MAX_POP));
          default: pop_q(REQ_W'($urandom_range(1, 8)));
        endcase
      end
    end
  endfunction

  // batches of pushes closed by end_of_batch, drained by matching pops
  function automatic void burst_queue(int n);
    int k;
    int made;
    made = 0;
    while (made < n) begin
      k = $urandom_range(1, 12);
      for (int j = 0; j < k; j++) push_q(rand_sample(), j == k - 1);
      if ($urandom_range(0, 3) == 0) begin
        pop_q(REQ_W'(k / 2 + 1));
        pop_q(REQ_W'(MAX_POP));
        made++;
      end else begin
        pop_q(REQ_W'(k));
      end
      if ($urandom_range(0, 5) == 0) begin
        pop_q($urandom_range(0, 1) ? '0 : REQ_W'($urandom_range(1, 3)));
        made++;
      end
      made += k + 1;
    end
  endfunction

  task automatic ring_settle();
    while (in_pend.size() != 0 || in_vld || beats_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_send(logic [CFG_IDX_W-1:0] idx, axis_t v);
    @(negedge clk);
    cfg_vld <= 1'b1;
    cfg_idx <= idx;
    cfg_dat <= v;
    do @(posedge clk); while (!cfg_if.ready);
  endtask

  task automatic cfg_release();
    @(negedge clk);
    cfg_vld <= 1'b0;
  endtask

  task automatic phase_cfg(ofs_style_e style, bit busy);
    cfg_reg_e r;
    axis_t v;
    r = r.first();
    repeat (NUM_AXES) begin
      case (style)
        OFS_TOP:    v = AXIS_MAX;
        OFS_BOTTOM: v = AXIS_MIN;
        OFS_ZERO:   v = '0;
        default:    v = rand_axis();
      endcase
      cfg_send(r, v);
      r = r.next();
    end
    if ($urandom_range(0, 1)) cfg_send(CFG_IDX_W'($urandom_range(2 ** CFG_IDX_W - 1, NUM_AXES)),
                                       rand_axis());
    cfg_release();
    busy_in = busy;
    busy_out = busy;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // offsets at reset value
    pop_q(REQ_W'(1));
    pop_q('0);
    push_q(smp_split(AXIS_MAX, AXIS_MAX), 1'b1);
    push_q(smp_split(AXIS_MIN, AXIS_MIN), 1'b0);
    push_q(smp_split(16'sh5555, 16'sh5555), 1'b0);
    push_q(smp_split(16'shaaaa, 16'shaaaa), 1'b1);
    pop_q('0);
    pop_q(REQ_W'(1));
    pop_q('1);
    pop_q(REQ_W'(MAX_POP));
    ring_settle();

    // saturate both ways, unknown register indexes dropped
    cfg_send(REG_OFS_ACCEL_X, AXIS_MAX);
    cfg_send(REG_OFS_ACCEL_Y, AXIS_MAX);
    cfg_send(REG_OFS_ACCEL_Z, AXIS_MAX);
    cfg_send(REG_OFS_GYRO_X, AXIS_MIN);
    cfg_send(REG_OFS_GYRO_Y, AXIS_MIN);
    cfg_send(REG_OFS_GYRO_Z, AXIS_MIN);
    cfg_send(CFG_IDX_W'(NUM_AXES), '0);
    cfg_send('1, '0);
    cfg_release();
    busy_in = 1'b1;
    busy_out = 1'b1;
    push_q(smp_split(AXIS_MAX, AXIS_MIN), 1'b1);
    push_q(smp_split(AXIS_MIN, AXIS_MAX), 1'b0);
    push_q(smp_split('0, '0), 1'b0);
    push_q(smp_split(-16'sd1, 16'sd1), 1'b1);
    pop_q(REQ_W'(4));
    ring_settle();

    phase_cfg(OFS_RANDOM, 1'b1);
    mix_queue(16);
    ring_settle();

    phase_cfg(OFS_TOP, 1'b0);
    burst_queue(10);
    ring_settle();

    // overrun the ring so the oldest entries drop
    phase_cfg(OFS_BOTTOM, 1'b1);
    repeat (RING_DEPTH + 1 - ring_count()) push_q(rand_sample(), 1'($urandom));
    pop_q(REQ_W'(1));
    push_q(rand_sample(), 1'b1);
    push_q(rand_sample(), 1'b0);
    repeat (5) pop_q(REQ_W'(MAX_POP));
    ring_settle();

    $display("Covered %0d pushes (%0d dropped the oldest), %0d pops (%0d without data).",
             pushes_seen, drops_seen, pops_seen, empty_pops);
    $display("Checked %0d result beats over %0d offset register writes, %0d mismatches.",
             beats_checked, reg_writes, err_count);
    if (err_count == 0 && beats_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
